FILE: hw/rtl/qlt_pkg.sv
// Shared types, character codes and limits for the quoted line tokenizer.
// Used by qlt_step, quoted_line_tokenizer and qlt_checker; depends on nothing.
package qlt_pkg;

  // Buffer sizes the length and count limits are capped by
  localparam int TOKEN_BYTES     = 64;
  localparam int MAX_LINE_TOKENS = 1024;

  localparam logic [7:0]  LEN_CAP = 8'(TOKEN_BYTES - 1);
  localparam logic [16:0] TOK_CAP = 17'(MAX_LINE_TOKENS);

  localparam logic [5:0]  MAX_TOKEN_LEN_RST = 6'd63;
  localparam logic [10:0] MAX_TOKENS_RST    = 11'd1024;

  // Register word addresses
  localparam logic REG_MAX_TOKEN_LEN = 1'b0;
  localparam logic REG_MAX_TOKENS    = 1'b1;

  typedef enum logic [2:0] {
    EV_BYTE = 3'd0,
    EV_END  = 3'd1,
    EV_DONE = 3'd2,
    EV_MANY = 3'd3,
    EV_LONG = 3'd4,
    EV_ESC  = 3'd5,
    EV_OPEN = 3'd6
  } ev_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;

  typedef struct packed {
    logic [5:0]  max_token_len;
    logic [10:0] max_tokens;
  } cfg_t;

  typedef struct packed {
    ev_t         event_res;
    logic [7:0]  char_out;
    logic [10:0] token_index;
    logic [5:0]  char_pos;
  } res_t;

  function automatic res_t mk_res(ev_t ev, logic [7:0] ch, logic [10:0] idx,
                                  logic [5:0] pos);
    res_t r;
    r.event_res   = ev;
    r.char_out    = ch;
    r.token_index = idx;
    r.char_pos    = pos;
    return r;
  endfunction

  // Returns {valid, mapped byte} for the letter after a backslash
  function automatic logic [8:0] map_escape(logic [7:0] b);
    logic [8:0] m;
    case (b)
      CH_LC_N:   m = {1'b1, CH_LF};
      CH_LC_T:   m = {1'b1, CH_TAB};
      CH_LC_R:   m = {1'b1, CH_CR};
      CH_LC_V:   m = {1'b1, CH_VT};
      CH_BSLASH: m = {1'b1, CH_BSLASH};
      CH_SQUOTE: m = {1'b1, CH_SQUOTE};
      CH_DQUOTE: m = {1'b1, CH_DQUOTE};
      CH_LC_B:   m = {1'b1, CH_BS};
      CH_LC_A:   m = {1'b1, CH_BEL};
      default:   m = {1'b0, CH_NUL};
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/qlt_step.sv
// Per-byte tokenizer step: line state registers plus the logic that turns
// one byte into up to four result words. Depends on qlt_pkg.
module qlt_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            byte_value,
  input  logic                  end_of_line,
  input  qlt_pkg::cfg_t         cfg,
  output qlt_pkg::res_t [3:0]   res,
  output logic [2:0]            res_cnt
);

  typedef struct packed {
    logic        in_string;
    logic        separated;
    logic        escape_pending;
    logic        aborted;
    logic [10:0] token_count;
    logic [5:0]  byte_count;
  } line_st_t;

  localparam line_st_t LINE_START = '{
    in_string: 1'b0, separated: 1'b1, escape_pending: 1'b0, aborted: 1'b0,
    token_count: 11'd0, byte_count: 6'd0
  };

  line_st_t            st_r;
  line_st_t            st_nxt;
  logic [7:0]          len_lim;
  logic [16:0]         tok_lim;
  logic                do_store;
  logic [7:0]          store_ch;
  logic [8:0]          esc_map;
  logic [2:0]          n;
  qlt_pkg::res_t [3:0] slot;

  assign len_lim = ({2'b00, cfg.max_token_len} < qlt_pkg::LEN_CAP) ?
                   {2'b00, cfg.max_token_len} : qlt_pkg::LEN_CAP;
  assign tok_lim = ({6'd0, cfg.max_tokens} < qlt_pkg::TOK_CAP) ?
                   {6'd0, cfg.max_tokens} : qlt_pkg::TOK_CAP;
  assign esc_map = qlt_pkg::map_escape(byte_value);

  always_comb begin
    st_nxt   = st_r;
    do_store = 1'b0;
    store_ch = byte_value;
    n        = 3'd0;
    slot     = '0;

    if (!st_nxt.aborted) begin
      if (st_nxt.escape_pending) begin
        st_nxt.escape_pending = 1'b0;
        do_store = 1'b1;
        if (esc_map[8]) begin
          store_ch = esc_map[7:0];
        end else begin
          // report the bad letter, then keep it as a plain byte
          slot[n[1:0]] = qlt_pkg::mk_res(qlt_pkg::EV_ESC, byte_value,
                                         st_nxt.token_count, st_nxt.byte_count);
          n = n + 3'd1;
        end
      end else if (byte_value inside {qlt_pkg::CH_DQUOTE, qlt_pkg::CH_SQUOTE}) begin
        st_nxt.in_string = !st_nxt.in_string;
      end else if (st_nxt.in_string && byte_value == qlt_pkg::CH_BSLASH) begin
        if (end_of_line) begin
          do_store = 1'b1;
        end else begin
          st_nxt.escape_pending = 1'b1;
        end
      end else if (!st_nxt.in_string &&
                   byte_value inside {qlt_pkg::CH_SPACE, qlt_pkg::CH_TAB, qlt_pkg::CH_LF,
                                      qlt_pkg::CH_CR, qlt_pkg::CH_NUL}) begin
        if (!st_nxt.separated) begin
          slot[n[1:0]] = qlt_pkg::mk_res(qlt_pkg::EV_END, qlt_pkg::CH_NUL,
                                         st_nxt.token_count, 6'd0);
          n = n + 3'd1;
          st_nxt.token_count = st_nxt.token_count + 11'd1;
          st_nxt.byte_count  = 6'd0;
          st_nxt.separated   = 1'b1;
        end
      end else begin
        do_store = 1'b1;
      end
    end

    if (do_store) begin
      if (st_nxt.byte_count == 6'd0 && {6'd0, st_nxt.token_count} >= tok_lim) begin
        slot[n[1:0]] = qlt_pkg::mk_res(qlt_pkg::EV_MANY, qlt_pkg::CH_NUL,
                                       st_nxt.token_count, 6'd0);
        n = n + 3'd1;
        st_nxt.aborted = 1'b1;
      end else if ({2'b00, st_nxt.byte_count} >= len_lim) begin
        slot[n[1:0]] = qlt_pkg::mk_res(qlt_pkg::EV_LONG, qlt_pkg::CH_NUL,
                                       st_nxt.token_count, st_nxt.byte_count);
        n = n + 3'd1;
        st_nxt.aborted = 1'b1;
      end else begin
        slot[n[1:0]] = qlt_pkg::mk_res(qlt_pkg::EV_BYTE, store_ch,
                                       st_nxt.token_count, st_nxt.byte_count);
        n = n + 3'd1;
        st_nxt.byte_count = st_nxt.byte_count + 6'd1;
        st_nxt.separated  = 1'b0;
      end
    end

    if (end_of_line) begin
      if (st_nxt.aborted) begin
        slot[n[1:0]] = qlt_pkg::mk_res(qlt_pkg::EV_DONE, qlt_pkg::CH_NUL, 11'd0, 6'd0);
        n = n + 3'd1;
      end else begin
        if (st_nxt.in_string) begin
          slot[n[1:0]] = qlt_pkg::mk_res(qlt_pkg::EV_OPEN, qlt_pkg::CH_NUL,
                                         st_nxt.token_count, 6'd0);
          n = n + 3'd1;
        end
        // line done closes an open last token without a token end
        if (!st_nxt.separated) begin
          st_nxt.token_count = st_nxt.token_count + 11'd1;
        end
        slot[n[1:0]] = qlt_pkg::mk_res(qlt_pkg::EV_DONE, qlt_pkg::CH_NUL,
                                       st_nxt.token_count, 6'd0);
        n = n + 3'd1;
      end
      st_nxt = LINE_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LINE_START;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign res     = slot;
  assign res_cnt = n;

endmodule

FILE: hw/rtl/quoted_line_tokenizer.sv
// Top level of the quoted line tokenizer: register port, input word register
// and result holding register. Depends on qlt_pkg and qlt_step.
//
//  channel   direction  handshake                 payload
//  in_*      slave      in_tvalid / in_tready     tdata byte_value, tlast end_of_line
//  out_*     master     out_tvalid / out_tready   tuser event_res, tdata fields, tlast
//  cfg_*     APB slave  psel & penable, pready=1  max_token_len @0, max_tokens @4
//
// A byte is held in the input register, then its 0 to 4 result words are
// loaded into the result register and leave one per output cycle unless
// out_tready stalls them; the next byte is handed over as the last word drains.
// in_tready drops while a byte is held and the result register still has more
// than its last word or that word is stalled. Reset is synchronous, active
// low; limits return to 63 bytes and 1024 tokens, line state to line start.
module quoted_line_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_value
  input  logic        in_tlast,    // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] char_out, [18:8] token_index, [24:19] char_pos
  output logic [2:0]  out_tuser,   // [2:0] event_res
  output logic        out_tlast,   // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  qlt_pkg::cfg_t       cfg_r;
  logic                in_v_r;
  logic [7:0]          in_byte_r;
  logic                in_eol_r;
  logic                advance;
  logic                take;
  qlt_pkg::res_t [3:0] step_res;
  logic [2:0]          step_cnt;
  qlt_pkg::res_t [3:0] slot_r;
  logic [2:0]          cnt_r;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == qlt_pkg::REG_MAX_TOKENS) ?
                      {21'd0, cfg_r.max_tokens} : {26'd0, cfg_r.max_token_len};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_token_len <= qlt_pkg::MAX_TOKEN_LEN_RST;
      cfg_r.max_tokens    <= qlt_pkg::MAX_TOKENS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == qlt_pkg::REG_MAX_TOKENS) begin
        cfg_r.max_tokens <= cfg_pwdata[10:0];
      end else begin
        cfg_r.max_token_len <= cfg_pwdata[5:0];
      end
    end
  end

  // hand the held byte over once the result register is empty or draining its last word
  assign take      = out_tvalid && out_tready;
  assign advance   = in_v_r && (cnt_r == 3'd0 || (cnt_r == 3'd1 && take));
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eol_r  <= in_tlast;
    end
  end

  qlt_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .byte_value  (in_byte_r),
    .end_of_line (in_eol_r),
    .cfg         (cfg_r),
    .res         (step_res),
    .res_cnt     (step_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (advance) begin
      cnt_r <= step_cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // load a fresh run, or advance the queue by one word
  always_ff @(posedge clk) begin
    if (advance) begin
      slot_r <= step_res;
    end else if (take) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
      slot_r[2] <= slot_r[3];
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tlast  = (cnt_r == 3'd1);
  assign out_tuser  = slot_r[0].event_res;
  assign out_tdata  = {7'd0, slot_r[0].char_pos, slot_r[0].token_index,
                       slot_r[0].char_out};

endmodule

FILE: hw/rtl/qlt_checker.sv
// Port-level checks for the quoted line tokenizer, bound to the top level.
// Depends on qlt_pkg and quoted_line_tokenizer.
module qlt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // line done is always the final word of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == qlt_pkg::EV_DONE |-> out_tlast)
    else $error("line done not marked last");

  // events without a byte carry zero char and position
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == qlt_pkg::EV_END || out_tuser == qlt_pkg::EV_DONE ||
                   out_tuser == qlt_pkg::EV_MANY || out_tuser == qlt_pkg::EV_OPEN)
    |-> out_tdata[7:0] == 8'd0 && out_tdata[24:19] == 6'd0)
    else $error("nonzero char or position on a byteless event");

  // reset drops pending results and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("results or stall survive reset");

endmodule

bind quoted_line_tokenizer qlt_checker u_qlt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
